FILE: src/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg: shared definitions for the scalar Kalman angle filter
// Field widths, configuration register codes and the controller command set.
// ----------------------------------------------------------------------------
package kaf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W     = 32;
    localparam int DT_W       = 17;
    localparam int NOISE_W    = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd2;

    // One strobe per datapath step; axis picks roll (0) or pitch (1)
    typedef struct packed {
        logic capture;
        logic mul1;
        logic pred;
        logic dstart;
        logic div_step;
        logic mul2;
        logic upd;
        logic load_out;
        logic axis;
    } t_dp_cmd;

endpackage

FILE: src/kaf_in_if.sv
// ----------------------------------------------------------------------------
// kaf_in_if: sample channel
// Valid/ready channel carrying gyro rate and measured angle for both axes.
// ----------------------------------------------------------------------------
interface kaf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_rate;
    logic signed [31:0] roll_measured;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] pitch_measured;

    modport source (
        output valid, roll_rate, roll_measured, pitch_rate, pitch_measured,
        input  ready
    );
    modport sink (
        input  valid, roll_rate, roll_measured, pitch_rate, pitch_measured,
        output ready
    );
endinterface

FILE: src/kaf_out_if.sv
// ----------------------------------------------------------------------------
// kaf_out_if: estimate channel
// Valid/ready channel carrying filtered angle and variance for both axes.
// ----------------------------------------------------------------------------
interface kaf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_estimate;
    logic        [31:0] roll_variance;
    logic signed [31:0] pitch_estimate;
    logic        [31:0] pitch_variance;

    modport source (
        output valid, roll_estimate, roll_variance, pitch_estimate, pitch_variance,
        input  ready
    );
    modport sink (
        input  valid, roll_estimate, roll_variance, pitch_estimate, pitch_variance,
        output ready
    );
endinterface

FILE: src/kaf_ctrl.sv
// ----------------------------------------------------------------------------
// kaf_ctrl: filter sequencer
// Steps the shared datapath through predict, divide and update for each axis.
// ----------------------------------------------------------------------------
module kaf_ctrl #(
    parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output kaf_pkg::t_dp_cmd o_cmd
);
    import kaf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL1   = 8'b0000_0010,
        S_PRED   = 8'b0000_0100,
        S_DSTART = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_MUL2   = 8'b0010_0000,
        S_UPD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_axis, n_axis;
    logic               r_out_valid, n_out_valid;
    logic               w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_axis        = 1'b0;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_PRED;
            end
            S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state    = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.dstart = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS)) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_MUL1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: src/kaf_datapath.sv
// ----------------------------------------------------------------------------
// kaf_datapath: shared arithmetic for both axes
// Filter state, configuration registers, multipliers and restoring divider.
// ----------------------------------------------------------------------------
module kaf_datapath #(
    parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kaf_pkg::t_dp_cmd                   i_cmd,
    input  logic                               i_cfg_we,
    input  logic [kaf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kaf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [kaf_pkg::DATA_W-1:0]  i_roll_rate,
    input  logic signed [kaf_pkg::DATA_W-1:0]  i_roll_measured,
    input  logic signed [kaf_pkg::DATA_W-1:0]  i_pitch_rate,
    input  logic signed [kaf_pkg::DATA_W-1:0]  i_pitch_measured,
    output logic signed [kaf_pkg::DATA_W-1:0]  o_roll_estimate,
    output logic        [kaf_pkg::DATA_W-1:0]  o_roll_variance,
    output logic signed [kaf_pkg::DATA_W-1:0]  o_pitch_estimate,
    output logic        [kaf_pkg::DATA_W-1:0]  o_pitch_variance
);
    import kaf_pkg::*;

    localparam int GW  = FRAC_BITS + 1;            // gain, at most 1.0
    localparam int P1W = DT_W + 1 + DATA_W;        // dt * rate
    localparam int P2W = GW + 1 + DATA_W + 1;      // gain * innovation
    localparam int P3W = GW + DATA_W;              // (1 - gain) * variance

    localparam logic [63:0] DT_FULL  = ((64'd3 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] QN_FULL  = ((64'd144 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] RN_FULL  = 64'd9 << FRAC_BITS;
    localparam logic [63:0] VAR_FULL = 64'd2 << FRAC_BITS;
    localparam logic [63:0] HALF     = 64'd1 << (FRAC_BITS - 1);

    localparam logic [GW-1:0]         ONE    = GW'(1) << FRAC_BITS;
    localparam logic signed [P1W:0]   HALF1  = HALF[P1W:0];
    localparam logic signed [P2W:0]   HALF2  = HALF[P2W:0];
    localparam logic [P3W:0]          HALF3  = HALF[P3W:0];

    // configuration
    logic [DT_W-1:0]    r_time_step;
    logic [NOISE_W-1:0] r_process_noise;
    logic [NOISE_W-1:0] r_measurement_noise;

    // filter state, one entry per axis
    logic signed [DATA_W-1:0] r_angle [2];
    logic        [DATA_W-1:0] r_var   [2];

    // captured sample
    logic signed [DATA_W-1:0] r_rate [2];
    logic signed [DATA_W-1:0] r_meas [2];

    // working registers
    logic signed [P1W-1:0]    r_p1;
    logic        [DATA_W-1:0] r_vp;
    logic signed [DATA_W-1:0] r_pred;
    logic        [DATA_W:0]   r_den;
    logic        [DATA_W+1:0] r_rem;
    logic        [GW-1:0]     r_gain;
    logic signed [DATA_W:0]   r_innov;
    logic signed [P2W-1:0]    r_p2;
    logic        [P3W-1:0]    r_p3;

    logic signed [DATA_W-1:0] r_roll_est, r_pitch_est;
    logic        [DATA_W-1:0] r_roll_var, r_pitch_var;

    logic signed [DATA_W-1:0] w_angle_sel, w_rate_sel, w_meas_sel;
    logic        [DATA_W-1:0] w_var_sel;
    logic        [DATA_W:0]   w_vp_sum;
    logic        [DATA_W-1:0] w_vp_sat;
    logic signed [P1W:0]      w_p1_rnd, w_pred_sum;
    logic signed [DATA_W-1:0] w_pred_sat;
    logic        [DATA_W+2:0] w_trial;
    logic                     w_qbit;
    logic        [DATA_W:0]   w_keep;
    logic        [GW-1:0]     w_gain_eff;
    logic        [GW-1:0]     w_one_minus;
    logic signed [P2W:0]      w_p2_rnd, w_est_sum;
    logic signed [DATA_W-1:0] w_est_sat;
    logic        [P3W:0]      w_p3_sum;
    logic        [DATA_W-1:0] w_var_new;

    assign w_angle_sel = r_angle[i_cmd.axis];
    assign w_var_sel   = r_var[i_cmd.axis];
    assign w_rate_sel  = r_rate[i_cmd.axis];
    assign w_meas_sel  = r_meas[i_cmd.axis];

    always_comb begin
        // predicted variance, clipped at the top of the 32-bit range
        w_vp_sum = {1'b0, w_var_sel} + {{(DATA_W + 1 - NOISE_W){1'b0}}, r_process_noise};
        w_vp_sat = w_vp_sum[DATA_W] ? '1 : w_vp_sum[DATA_W-1:0];

        // predicted angle: round the rate product, add, saturate
        w_p1_rnd   = ($signed({r_p1[P1W-1], r_p1}) + HALF1) >>> FRAC_BITS;
        w_pred_sum = $signed({{(P1W + 1 - DATA_W){w_angle_sel[DATA_W-1]}}, w_angle_sel})
                   + w_p1_rnd;
        if ((&w_pred_sum[P1W:DATA_W-1]) || !(|w_pred_sum[P1W:DATA_W-1])) begin
            w_pred_sat = w_pred_sum[DATA_W-1:0];
        end else begin
            w_pred_sat = w_pred_sum[P1W] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                         : {1'b0, {(DATA_W - 1){1'b1}}};
        end

        // one restoring division step: compare, subtract, shift
        w_trial = {1'b0, r_rem} - {2'b00, r_den};
        w_qbit  = ~w_trial[DATA_W+2];
        w_keep  = w_qbit ? w_trial[DATA_W:0] : r_rem[DATA_W:0];

        // zero denominator means zero gain
        w_gain_eff  = (r_den == '0) ? '0 : r_gain;
        w_one_minus = ONE - w_gain_eff;

        // updated angle
        w_p2_rnd  = ($signed({r_p2[P2W-1], r_p2}) + HALF2) >>> FRAC_BITS;
        w_est_sum = $signed({{(P2W + 1 - DATA_W){r_pred[DATA_W-1]}}, r_pred}) + w_p2_rnd;
        if ((&w_est_sum[P2W:DATA_W-1]) || !(|w_est_sum[P2W:DATA_W-1])) begin
            w_est_sat = w_est_sum[DATA_W-1:0];
        end else begin
            w_est_sat = w_est_sum[P2W] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                       : {1'b0, {(DATA_W - 1){1'b1}}};
        end

        // updated variance, kept to 32 bits
        w_p3_sum  = {1'b0, r_p3} + HALF3;
        w_var_new = w_p3_sum[FRAC_BITS +: DATA_W];
    end

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step         <= DT_FULL[DT_W-1:0];
            r_process_noise     <= QN_FULL[NOISE_W-1:0];
            r_measurement_noise <= RN_FULL[NOISE_W-1:0];
            r_angle[0]          <= '0;
            r_angle[1]          <= '0;
            r_var[0]            <= VAR_FULL[DATA_W-1:0];
            r_var[1]            <= VAR_FULL[DATA_W-1:0];
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TIME_STEP:         r_time_step         <= i_cfg_data[DT_W-1:0];
                    CFG_PROCESS_NOISE:     r_process_noise     <= i_cfg_data[NOISE_W-1:0];
                    CFG_MEASUREMENT_NOISE: r_measurement_noise <= i_cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd) begin
                r_angle[i_cmd.axis] <= w_est_sat;
                r_var[i_cmd.axis]   <= w_var_new;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rate[0] <= i_roll_rate;
            r_meas[0] <= i_roll_measured;
            r_rate[1] <= i_pitch_rate;
            r_meas[1] <= i_pitch_measured;
        end
        if (i_cmd.mul1) begin
            r_p1 <= $signed({1'b0, r_time_step}) * w_rate_sel;
            r_vp <= w_vp_sat;
        end
        if (i_cmd.pred) begin
            r_pred <= w_pred_sat;
            r_den  <= {1'b0, r_vp} + {{(DATA_W + 1 - NOISE_W){1'b0}}, r_measurement_noise};
        end
        if (i_cmd.dstart) begin
            r_rem   <= {2'b00, r_vp};
            r_gain  <= '0;
            r_innov <= $signed({w_meas_sel[DATA_W-1], w_meas_sel})
                     - $signed({r_pred[DATA_W-1], r_pred});
        end
        if (i_cmd.div_step) begin
            r_rem  <= {w_keep, 1'b0};
            r_gain <= {r_gain[GW-2:0], w_qbit};
        end
        if (i_cmd.mul2) begin
            r_p2 <= $signed({1'b0, w_gain_eff}) * r_innov;
            r_p3 <= w_one_minus * r_vp;
        end
        if (i_cmd.load_out) begin
            r_roll_est  <= r_angle[0];
            r_roll_var  <= r_var[0];
            r_pitch_est <= r_angle[1];
            r_pitch_var <= r_var[1];
        end
    end

    assign o_roll_estimate  = r_roll_est;
    assign o_roll_variance  = r_roll_var;
    assign o_pitch_estimate = r_pitch_est;
    assign o_pitch_variance = r_pitch_var;

endmodule

FILE: src/kalman_1d_angle_filter.sv
// ----------------------------------------------------------------------------
// kalman_1d_angle_filter: two-axis scalar Kalman angle filter
// Fuses gyro rate and accelerometer angle for roll and pitch, Q16.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one sample (rate and measured angle per axis); a transfer
//   happens on a rising edge with valid and ready high. Ready is high only
//   while the sequencer is idle.
//   o_out carries the filtered angle and variance of both axes from an
//   output register. A new sample is taken while a finished result still
//   waits there; if the receiver stalls, the next result holds in the
//   datapath until the output register is free, then advances.
//   Timing: roll then pitch go through one shared datapath. Each axis is
//   paced by the restoring divider for the gain, which yields one quotient
//   bit per cycle (FRAC_BITS + 1 bits, 17 for Q16.16). Output valid rises
//   once both axes are updated and the output register takes the result;
//   the next sample is taken only after that, when the sequencer is idle.
//   Configuration: i_cfg_we writes register i_cfg_index (0 time step,
//   1 process noise, 2 measurement noise); other indexes are dropped.
//   Write only while the filter is idle.
//   Reset (synchronous, active low) clears both angles, sets both variances
//   to 2.0, loads default registers and drops any pending result.
// ----------------------------------------------------------------------------
module kalman_1d_angle_filter #(
    parameter int FRAC_BITS = kaf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kaf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kaf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kaf_in_if.sink                         i_in,
    kaf_out_if.source                      o_out
);
    import kaf_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer: owns the handshakes and the output valid flag
    kaf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic, filter state and output payload register
    kaf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_roll_rate      (i_in.roll_rate),
        .i_roll_measured  (i_in.roll_measured),
        .i_pitch_rate     (i_in.pitch_rate),
        .i_pitch_measured (i_in.pitch_measured),
        .o_roll_estimate  (o_out.roll_estimate),
        .o_roll_variance  (o_out.roll_variance),
        .o_pitch_estimate (o_out.pitch_estimate),
        .o_pitch_variance (o_out.pitch_variance)
    );

endmodule

FILE: verif/kaf_estimate_checker.sv
// ----------------------------------------------------------------------------
// kaf_estimate_checker: prediction and comparison for the Kalman angle filter
// Watches the configuration port and both channels, runs its own two-axis
// scalar Kalman step on every accepted sample and checks each accepted
// estimate against the oldest prediction. Hands the failure count and the
// number of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module kaf_estimate_checker
    import kaf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kaf_in_if                     i_in_ch,
    kaf_out_if                    i_out_ch,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int     FRAC     = FRAC_BITS_DEF;
    localparam longint ONE_Q    = 64'sd1 << FRAC;
    localparam longint HALF_LSB = 64'sd1 << (FRAC - 1);
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;
    localparam longint U32_MAX  = 64'sd4294967295;

    typedef struct packed {
        logic [DATA_W-1:0] roll_est;
        logic [DATA_W-1:0] roll_var;
        logic [DATA_W-1:0] pitch_est;
        logic [DATA_W-1:0] pitch_var;
    } t_estimate;

    // Register copies
    logic [DT_W-1:0]    dt_q;
    logic [NOISE_W-1:0] qn_q;
    logic [NOISE_W-1:0] rn_q;

    // Filter state copies
    logic signed [DATA_W-1:0] roll_angle;
    logic        [DATA_W-1:0] roll_variance;
    logic signed [DATA_W-1:0] pitch_angle;
    logic        [DATA_W-1:0] pitch_variance;

    t_estimate expected_estimates[$];
    int        fail_count   = 0;
    int        pending      = 0;
    int        result_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Shift a product down by the fraction bits, half an LSB rounding up
    function automatic longint round_shift(input longint v);
        return (v + HALF_LSB) >>> FRAC;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // One predict/update step of a single axis
    function automatic void kalman_axis_step(
        inout logic signed [DATA_W-1:0] angle,
        inout logic        [DATA_W-1:0] variance,
        input logic signed [DATA_W-1:0] rate,
        input logic signed [DATA_W-1:0] meas
    );
        longint pred;
        longint vp;
        longint den;
        longint gain;
        longint est;
        pred = clamp_s32(longint'(angle) + round_shift(longint'(dt_q) * longint'(rate)));
        vp   = longint'(variance) + longint'(qn_q);
        if (vp > U32_MAX)
            vp = U32_MAX;
        den  = vp + longint'(rn_q);
        gain = (den != 0) ? (vp << FRAC) / den : 64'sd0;
        est  = pred + round_shift(gain * (longint'(meas) - pred));
        angle    = 32'(clamp_s32(est));
        variance = 32'(round_shift((ONE_Q - gain) * vp));
    endfunction

    always @(posedge i_clk) begin : watch
        t_estimate want;
        t_estimate got;
        if (!i_rst_n) begin
            dt_q           = DT_W'(1966);
            qn_q           = NOISE_W'(944);
            rn_q           = NOISE_W'(589824);
            roll_angle     = '0;
            pitch_angle    = '0;
            roll_variance  = 32'(2 * ONE_Q);
            pitch_variance = 32'(2 * ONE_Q);
            expected_estimates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:         dt_q = i_cfg_data[DT_W-1:0];
                    CFG_PROCESS_NOISE:     qn_q = i_cfg_data[NOISE_W-1:0];
                    CFG_MEASUREMENT_NOISE: rn_q = i_cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end

            // Results first: a result never belongs to a sample taken at the same edge
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = '{i_out_ch.roll_estimate, i_out_ch.roll_variance,
                        i_out_ch.pitch_estimate, i_out_ch.pitch_variance};
                if (expected_estimates.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d with nothing outstanding: roll %h/%h pitch %h/%h",
                                 result_count, got.roll_est, got.roll_var,
                                 got.pitch_est, got.pitch_var);
                end else begin
                    want = expected_estimates.pop_front();
                    if (got.roll_est !== want.roll_est || got.roll_var !== want.roll_var ||
                        got.pitch_est !== want.pitch_est ||
                        got.pitch_var !== want.pitch_var) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result %0d mismatch: want roll %h/%h pitch %h/%h",
                                     result_count, want.roll_est, want.roll_var,
                                     want.pitch_est, want.pitch_var);
                            $display("    got roll %h/%h pitch %h/%h",
                                     got.roll_est, got.roll_var,
                                     got.pitch_est, got.pitch_var);
                        end
                    end
                end
                result_count++;
            end

            if (i_in_ch.valid && i_in_ch.ready) begin
                kalman_axis_step(roll_angle, roll_variance,
                                 i_in_ch.roll_rate, i_in_ch.roll_measured);
                kalman_axis_step(pitch_angle, pitch_variance,
                                 i_in_ch.pitch_rate, i_in_ch.pitch_measured);
                want = '{roll_angle, roll_variance, pitch_angle, pitch_variance};
                expected_estimates.push_back(want);
            end
        end
        pending = expected_estimates.size();
    end

endmodule

FILE: verif/tb_kalman_1d_angle_filter.sv
// ----------------------------------------------------------------------------
// tb_kalman_1d_angle_filter: regression for the two-axis Kalman angle filter
// Drives samples and register settings into the filter under random source
// and sink stalls; a checker beside the filter predicts and compares every
// estimate. Directed extremes come first, then random blocks under varied
// settings, and the verdict follows once the checker has nothing left.
// ----------------------------------------------------------------------------
module tb_kalman_1d_angle_filter;
    import kaf_pkg::*;

    localparam int Q1      = 1 << FRAC_BITS_DEF;   // 1.0 in Q16.16
    localparam int BLOCKS  = 8;
    localparam int PER_BLK = 250;

    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kaf_in_if  in_ch ();
    kaf_out_if out_ch ();

    int fail_count;
    int pending;
    int src_idle_pct  = 18;
    int sink_idle_pct = 88;

    kalman_1d_angle_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    kaf_estimate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run, stalls on both sides included
    initial begin
        #10_000_000;
        $display("kalman_1d_angle_filter regression: fail");
        $finish;
    end

    // Sink side: drop ready at random, one decision per cycle
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one sample and hold it until the filter takes it. Valid stays high
    // on return, so back-to-back samples keep it high unless the source idles.
    task automatic send_sample(input logic [DATA_W-1:0] roll_rate,
                               input logic [DATA_W-1:0] roll_meas,
                               input logic [DATA_W-1:0] pitch_rate,
                               input logic [DATA_W-1:0] pitch_meas);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.roll_rate      <= roll_rate;
        in_ch.roll_measured  <= roll_meas;
        in_ch.pitch_rate     <= pitch_rate;
        in_ch.pitch_measured <= pitch_meas;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // Pause the source until every estimate is back, so the filter is idle,
    // then write all three registers plus one write to an unused index,
    // which must be dropped
    task automatic set_config(input logic [CFG_DATA_W-1:0] dt,
                              input logic [CFG_DATA_W-1:0] qn,
                              input logic [CFG_DATA_W-1:0] rn);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_STEP;
        cfg_data  <= dt;
        @(posedge i_clk);
        cfg_index <= CFG_PROCESS_NOISE;
        cfg_data  <= qn;
        @(posedge i_clk);
        cfg_index <= CFG_MEASUREMENT_NOISE;
        cfg_data  <= rn;
        @(posedge i_clk);
        cfg_index <= CFG_MEASUREMENT_NOISE + 2'd1;
        cfg_data  <= '1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly plausible sensor values, then raw words and the range corners
    function automatic logic [DATA_W-1:0] random_field(input bit is_rate);
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            if (is_rate)
                return $urandom_range(1000 * Q1) - 500 * Q1;
            return $urandom_range(360 * Q1) - 180 * Q1;
        end
        if (sel < 85)
            return $urandom();
        case ($urandom_range(3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] dt;
        logic [CFG_DATA_W-1:0] qn;
        logic [CFG_DATA_W-1:0] rn;
        int                    n;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_TIME_STEP;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.roll_rate      <= '0;
        in_ch.roll_measured  <= '0;
        in_ch.pitch_rate     <= '0;
        in_ch.pitch_measured <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero sample, plain values and the field corners
        send_sample('0, '0, '0, '0);
        send_sample(10 * Q1, 5 * Q1, -10 * Q1, -5 * Q1);
        send_sample(S_MAX, S_MAX, S_MIN, S_MIN);
        send_sample(S_MIN, S_MIN, S_MAX, S_MAX);
        send_sample('1, 32'd1, 32'd1, '1);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);

        // A step of 1.0, no process noise, tiny measurement noise: the estimate
        // tracks the measurement, so full-scale rates push the prediction
        // into saturation at both ends
        set_config(65536, 0, 1);
        repeat (3) send_sample(S_MAX, S_MAX, S_MIN, S_MIN);
        repeat (2) send_sample(S_MIN, S_MIN, S_MAX, S_MAX);

        // No noise at all: first step collapses the variance, after that the
        // denominator is zero and the gain must be zero
        set_config(0, 0, 0);
        repeat (3) send_sample(Q1, 3 * Q1, -Q1, -3 * Q1);

        // Large noise values (256.0 each)
        set_config(65536, 16777216, 16777216);
        send_sample(S_MAX, S_MIN, S_MIN, S_MAX);
        send_sample(S_MIN, S_MAX, S_MAX, S_MIN);
        send_sample(100 * Q1, -20 * Q1, -100 * Q1, 20 * Q1);

        // Random blocks, each under its own settings; the pause at every
        // block boundary drains the filter completely
        for (int blk = 0; blk < BLOCKS; blk++) begin
            case ($urandom_range(3))
                0:       dt = 0;
                1:       dt = 65536;
                2:       dt = 1966;
                default: dt = $urandom_range(65536);
            endcase
            case ($urandom_range(3))
                0:       qn = 0;
                1:       qn = 16777216;
                2:       qn = 944;
                default: qn = $urandom_range(16777216) >> $urandom_range(20);
            endcase
            case ($urandom_range(3))
                0:       rn = 1;
                1:       rn = 16777216;
                2:       rn = 589824;
                default: rn = 1 + ($urandom_range(16777215) >> $urandom_range(20));
            endcase
            set_config(dt, qn, rn);
            for (int k = 0; k < PER_BLK; k++) begin
                n = blk * PER_BLK + k;
                // Slow sink first, then slow source, then full rate
                if (n < BLOCKS * PER_BLK / 3) begin
                    src_idle_pct  = 18;
                    sink_idle_pct = 88;
                end else if (n < 2 * BLOCKS * PER_BLK / 3) begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 18;
                end else begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                send_sample(random_field(1'b1), random_field(1'b0),
                            random_field(1'b1), random_field(1'b0));
            end
        end

        // Drain, then keep watching for stray results before the verdict
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("kalman_1d_angle_filter regression: pass");
        end else begin
            $display("kalman_1d_angle_filter regression: fail");
        end
        $finish;
    end

endmodule
